[rtl/otsu_threshold_histogram_unit_defines.svh]
// Assertion macros for the checker file of the Otsu threshold unit.
`ifndef OTSU_THRESHOLD_HISTOGRAM_UNIT_DEFINES_SVH
`define OTSU_THRESHOLD_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define OTH_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define OTH_ASSERT_NXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define OTH_ASSERT_NXT_ALL(label, clk, cond, expr, msg) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error(msg);

`endif

[rtl/oth_pkg.sv]
// Types and constants shared across the Otsu threshold unit.
`timescale 1ns / 1ps
package oth_pkg;

   // Grey level width and histogram geometry
   localparam int unsigned        PIXEL_W   = 8;
   localparam int unsigned        NUM_BINS  = 256;
   localparam logic [PIXEL_W-1:0] TOP_LEVEL = 8'hFF;

   // Main controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_READ,
      ST_LOAD,
      ST_CHECK,
      ST_MUL,
      ST_WAIT,
      ST_OUT
   } state_type;

   // Products evaluated for one candidate threshold, in order
   typedef enum logic [2:0] {
      MOP_A,
      MOP_B,
      MOP_Q,
      MOP_D2,
      MOP_LHS,
      MOP_RHS
   } mul_op_type;

endpackage

[rtl/oth_if.sv]
// Valid/ready channel interfaces for pixel input and threshold output.
`timescale 1ns / 1ps
interface oth_req_if;
   import oth_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_last;

   modport source (output valid, output pixel, output frame_last, input ready);
   modport sink   (input valid, input pixel, input frame_last, output ready);
endinterface

interface oth_rsp_if;
   import oth_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] threshold;

   modport source (output valid, output threshold, input ready);
   modport sink   (input valid, input threshold, output ready);
endinterface

[rtl/otsu_threshold_histogram_unit.sv]
// Otsu threshold unit: histogram of one frame and a serial threshold search.
//
// Pixels stream in at one per cycle while ready is high and are counted into a
// 256-bin histogram held in a RAM, with a one-entry bypass for back-to-back
// hits on the same bin. Pixels beyond MAX_PIXELS in a frame are not counted.
// The pixel marked frame_last ends the frame; the input then stalls while bins
// 0..255 are swept, read and zeroed. A bin that is empty or leaves one class
// empty is skipped; every other bin is scored with six products on one shared
// shift-add multiplier that takes one multiplier bit per cycle. The result
// sits in an output register, so the next frame's pixels are taken while it
// waits. After reset a clearing pass zeroes bins 0..255 before the first pixel
// is accepted. The threshold is the first t that strictly maximizes the
// between-class variance, and 0 if no split has both classes non-empty.
`timescale 1ns / 1ps
module otsu_threshold_histogram_unit #(
   parameter int unsigned MAX_PIXELS = 4194304
) (
   input logic          clock,
   input logic          reset,
   oth_req_if.sink      req_ch,
   oth_rsp_if.source    rsp_ch
);
   import oth_pkg::*;

   localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int unsigned SUM_W  = CNT_W + PIXEL_W;
   localparam int unsigned PROD_W = CNT_W + SUM_W;
   localparam int unsigned Q_W    = 2 * CNT_W;
   localparam int unsigned D2_W   = 2 * PROD_W;
   localparam int unsigned CMP_W  = D2_W + Q_W;

   // Control state
   state_type          state_ff, state_in;
   logic [PIXEL_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_thr_ff, rsp_thr_in;

   // Accumulate stage and write bypass
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_addr_ff;
   logic               fwd_valid_ff;
   logic [PIXEL_W-1:0] fwd_addr_ff;
   logic [CNT_W-1:0]   fwd_data_ff;
   logic [CNT_W-1:0]   bin_cur, bin_inc;

   // Search datapath
   mul_op_type         op_ff, op_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   nb_ff, nb_in;
   logic [SUM_W-1:0]   sb_ff, sb_in;
   logic [CNT_W-1:0]   nf_ff, nf_in;
   logic [PROD_W-1:0]  a_ff, a_in;
   logic [PROD_W-1:0]  d_ff, d_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [D2_W-1:0]    d2_ff, d2_in;
   logic [CMP_W-1:0]   lhs_ff, lhs_in;
   logic [D2_W-1:0]    best_d2_ff, best_d2_in;
   logic [Q_W-1:0]     best_q_ff, best_q_in;
   logic [PIXEL_W-1:0] best_t_ff, best_t_in;
   logic [PROD_W-1:0]  b_prod, d_abs;

   // RAM and multiplier hookup
   logic               ram_wr_en;
   logic [PIXEL_W-1:0] ram_wr_addr;
   logic [CNT_W-1:0]   ram_wr_data;
   logic [PIXEL_W-1:0] ram_rd_addr;
   logic [CNT_W-1:0]   ram_rd_data;
   logic               mul_start;
   logic [D2_W-1:0]    mul_x;
   logic [PROD_W-1:0]  mul_y;
   logic               mul_done;
   logic [CMP_W-1:0]   mul_prod;

   logic               req_fire;
   logic               count_ok;

   // Handshake
   assign req_ch.ready     = (state_ff == ST_RUN);
   assign req_fire         = req_ch.valid && req_ch.ready;
   assign count_ok         = (total_ff < CNT_W'(MAX_PIXELS));
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.threshold = rsp_thr_ff;

   // Bin increment, bypassing the write of the previous cycle
   assign bin_cur = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff
                                                                   : ram_rd_data;
   assign bin_inc = bin_cur + CNT_W'(1);
   assign s1_valid_in = req_fire && count_ok;

   // Write port: increments first, zeroing during sweeps
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = s1_addr_ff;
      ram_wr_data = bin_inc;
      if (s1_valid_ff) begin
         ram_wr_en = 1'b1;
      end else if ((state_ff == ST_CLEAR) || (state_ff == ST_READ)) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = idx_ff;
         ram_wr_data = '0;
      end
   end

   assign ram_rd_addr = (state_ff == ST_READ) ? idx_ff : req_ch.pixel;

   oth_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Multiplier operands per product
   always_comb begin
      unique case (op_ff)
         MOP_A: begin
            mul_x = D2_W'(sb_ff);
            mul_y = PROD_W'(total_ff);
         end
         MOP_B: begin
            mul_x = D2_W'(sum_ff);
            mul_y = PROD_W'(nb_ff);
         end
         MOP_Q: begin
            mul_x = D2_W'(nf_ff);
            mul_y = PROD_W'(nb_ff);
         end
         MOP_D2: begin
            mul_x = D2_W'(d_ff);
            mul_y = d_ff;
         end
         MOP_LHS: begin
            mul_x = d2_ff;
            mul_y = PROD_W'(best_q_ff);
         end
         MOP_RHS: begin
            mul_x = best_d2_ff;
            mul_y = PROD_W'(q_ff);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   oth_mul #(
      .X_W (D2_W),
      .Y_W (PROD_W),
      .P_W (CMP_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Distance |N*Sb - nb*S|
   assign b_prod = mul_prod[PROD_W-1:0];
   assign d_abs  = (a_ff >= b_prod) ? (a_ff - b_prod) : (b_prod - a_ff);

   // Next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_thr_in   = rsp_thr_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      nb_in        = nb_ff;
      sb_in        = sb_ff;
      nf_in        = nf_ff;
      a_in         = a_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      d2_in        = d2_ff;
      lhs_in       = lhs_ff;
      best_d2_in   = best_d2_ff;
      best_q_in    = best_q_ff;
      best_t_in    = best_t_ff;
      mul_start    = 1'b0;

      // drop the result once it is transferred
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == TOP_LEVEL) begin
               idx_in   = '0;
               state_in = ST_RUN;
            end else begin
               idx_in = idx_ff + PIXEL_W'(1);
            end
         end
         ST_RUN: begin
            if (req_fire) begin
               if (count_ok) begin
                  total_in = total_ff + CNT_W'(1);
                  sum_in   = sum_ff + SUM_W'(req_ch.pixel);
               end
               if (req_ch.frame_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            idx_in     = '0;
            nb_in      = '0;
            sb_in      = '0;
            best_d2_in = '0;
            best_q_in  = Q_W'(1);
            best_t_in  = '0;
            state_in   = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cnt_in = ram_rd_data;
            nb_in  = nb_ff + ram_rd_data;
            sb_in  = sb_ff + (SUM_W'(ram_rd_data) * SUM_W'(idx_ff));
            if (idx_ff == TOP_LEVEL) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // an empty bin repeats the previous split and cannot win; a split with an empty class is skipped too
            if ((cnt_ff == '0) || (nb_ff == '0) || (nb_ff >= total_ff)) begin
               idx_in   = idx_ff + PIXEL_W'(1);
               state_in = ST_READ;
            end else begin
               nf_in    = total_ff - nb_ff;
               op_in    = MOP_A;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               state_in = ST_MUL;
               unique case (op_ff)
                  MOP_A: begin
                     a_in  = mul_prod[PROD_W-1:0];
                     op_in = MOP_B;
                  end
                  MOP_B: begin
                     d_in  = d_abs;
                     op_in = MOP_Q;
                  end
                  MOP_Q: begin
                     q_in  = mul_prod[Q_W-1:0];
                     op_in = MOP_D2;
                  end
                  MOP_D2: begin
                     d2_in = mul_prod[D2_W-1:0];
                     op_in = MOP_LHS;
                  end
                  MOP_LHS: begin
                     lhs_in = mul_prod;
                     op_in  = MOP_RHS;
                  end
                  MOP_RHS: begin
                     // keep the candidate only on a strict improvement
                     if (lhs_ff > mul_prod) begin
                        best_d2_in = d2_ff;
                        best_q_in  = q_ff;
                        best_t_in  = idx_ff;
                     end
                     idx_in   = idx_ff + PIXEL_W'(1);
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_thr_in   = best_t_ff;
               total_in     = '0;
               sum_in       = '0;
               idx_in       = '0;
               state_in     = ST_RUN;
            end
         end
         default: begin
            idx_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         total_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_thr_ff  <= rsp_thr_in;
      s1_addr_ff  <= req_ch.pixel;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= bin_inc;
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      nb_ff       <= nb_in;
      sb_ff       <= sb_in;
      nf_ff       <= nf_in;
      a_ff        <= a_in;
      d_ff        <= d_in;
      q_ff        <= q_in;
      d2_ff       <= d2_in;
      lhs_ff      <= lhs_in;
      best_d2_ff  <= best_d2_in;
      best_q_ff   <= best_q_in;
      best_t_ff   <= best_t_in;
   end

endmodule

[rtl/oth_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module oth_ram #(
   parameter int unsigned WIDTH = 23,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read the old contents on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/oth_mul.sv]
// Shift-add serial multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module oth_mul #(
   parameter int unsigned X_W = 108,
   parameter int unsigned Y_W = 54,
   parameter int unsigned P_W = 154
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [X_W-1:0] x,
   input  logic [Y_W-1:0] y,
   output logic           done,
   output logic [P_W-1:0] product
);

   logic           run_ff, run_in;
   logic [P_W-1:0] x_ff, x_in;
   logic [Y_W-1:0] y_ff, y_in;
   logic [P_W-1:0] acc_ff, acc_in;

   // Finished once the remaining multiplier bits are all zero
   assign done    = run_ff && (y_ff == '0);
   assign product = acc_ff;

   // Load operands, then add the shifted multiplicand for each set bit
   always_comb begin
      run_in = run_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      acc_in = acc_ff;
      if (start) begin
         run_in = 1'b1;
         x_in   = P_W'(x);
         y_in   = y;
         acc_in = '0;
      end else if (run_ff) begin
         if (y_ff == '0) begin
            run_in = 1'b0;
         end else begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = x_ff << 1;
            y_in = y_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

endmodule

[rtl/oth_checker.sv]
// Port-level checks for the Otsu threshold unit, bound to the top level.
`timescale 1ns / 1ps
`include "otsu_threshold_histogram_unit_defines.svh"
module oth_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_frame_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [oth_pkg::PIXEL_W-1:0] rsp_threshold
);
   import oth_pkg::*;

   // A split at the top level would leave the foreground empty
   `OTH_ASSERT_IMP(a_thr_range, clock, reset, rsp_valid, rsp_threshold != TOP_LEVEL, "threshold at top level")

   // Hold a stalled result
   `OTH_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_threshold), "stalled result changed")

   // Stall input while the last pixel drains and the search starts
   `OTH_ASSERT_NXT(a_search_stall, clock, reset, req_valid && req_ready && req_frame_last, !req_ready ##1 !req_ready, "input taken during search")

   // Stall input as the clearing pass starts after reset
   `OTH_ASSERT_NXT_ALL(a_clear_stall, clock, reset, !req_ready, "input taken during clearing pass")

endmodule

bind otsu_threshold_histogram_unit oth_checker u_oth_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_frame_last (req_ch.frame_last),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_threshold  (rsp_ch.threshold)
);
